[rtl/pss_pkg.sv]
// ----------------------------------------------------------------------------
// pss_pkg: shared types and codes of the process slot scheduler
// Slot status codes, command codes and the beat structs of both channels.
// ----------------------------------------------------------------------------
package pss_pkg;

    typedef enum logic [1:0] {
        ST_RUN     = 2'd0,
        ST_READY   = 2'd1,
        ST_BLOCKED = 2'd2,
        ST_EXIT    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FN_SCHEDULE       = 3'd0,
        FN_EXIT           = 3'd1,
        FN_BLOCK          = 3'd2,
        FN_RUN            = 3'd3,
        FN_EXIT_TO_PARENT = 3'd4,
        FN_WAIT           = 3'd5,
        FN_FORK           = 3'd6,
        FN_START          = 3'd7
    } func_t;

    localparam logic [7:0] FORK_FAIL_CODE = 8'hFF;

    typedef struct packed {
        func_t      func;
        logic [2:0] slot;
        logic [7:0] value;
    } in_t;

    typedef struct packed {
        logic [2:0] current_slot;
        logic [7:0] result_value;
        logic       fork_failed;
    } out_t;

endpackage

[rtl/pss_table.sv]
// ----------------------------------------------------------------------------
// pss_table: one field of the slot table
// Single write port, one registered read port; per-entry valid bits make an
// entry that was never written read as the reset value.
// ----------------------------------------------------------------------------
module pss_table #(
    parameter int unsigned         DEPTH   = 8,
    parameter int unsigned         WIDTH   = 8,
    parameter int unsigned         AW      = 3,
    parameter logic [WIDTH-1:0]    RST_VAL = '0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Unwritten entries read as reset value
    assign rd_data = rd_valid_reg ? rd_data_reg : RST_VAL;

endmodule

[rtl/process_slot_scheduler.sv]
// ----------------------------------------------------------------------------
// process_slot_scheduler: round-robin scheduler over a table of process slots
// Holds status, parent and mailbox per slot plus the current-slot pointer and
// executes one scheduler command per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one command beat (func, slot, value);
//   m_valid/m_ready/m_data return one result beat per command (current slot
//   after the command, result byte, fork failure flag).
//   One command is in flight at a time; s_ready is high only while idle.
//   Exit, block, run and start update the tables directly; schedule and
//   fork scan the status table, exit_to_parent wakes the parent before its
//   scan, and wait reads the mailbox after its scan.
//   The schedule and fork scans walk the status table one slot per cycle
//   through its single registered read port, sharing one index incrementer.
//   The result sits in an output register, so the next command is taken
//   while a result waits; a finished command holds until that register is
//   free. A stalled receiver therefore stops the block after one command.
//   Reset (aresetn low, synchronous) marks every slot exited with parent 0
//   and mailbox 0, sets current to slot 0 and drops any pending result.
// ----------------------------------------------------------------------------
module process_slot_scheduler #(
    parameter int unsigned SLOTS = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pss_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output pss_pkg::out_t m_data
);

    localparam int unsigned IDX_W = $clog2(SLOTS);
    localparam int unsigned CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_PAR_WR,
        S_START,
        S_SCAN,
        S_MB_RD,
        S_MB_DATA,
        S_FORK_WR,
        S_FORK_MB,
        S_FORK_FAIL,
        S_FINISH
    } state_t;

    state_t          state_reg, state_next;
    pss_pkg::func_t  func_reg, func_next;
    logic [2:0]      slot_reg, slot_next;
    logic [7:0]      value_reg, value_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    // scan pipeline: address to issue, issue count, read in flight
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             have_rdy_reg, have_rdy_next;
    logic [IDX_W-1:0] rdy_idx_reg, rdy_idx_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [7:0]       res_reg, res_next;
    logic             fail_reg, fail_next;
    logic             m_valid_reg, m_valid_next;
    pss_pkg::out_t    m_data_reg, m_data_next;

    // table ports
    logic             st_we, par_we, mb_we;
    logic [IDX_W-1:0] st_wa, par_wa, mb_wa;
    logic [1:0]       st_wd, st_rd;
    logic [IDX_W-1:0] par_wd, par_rd;
    logic [7:0]       mb_wd, mb_rd;

    // shared index unit: step to the next slot, skipping slot 0 on wrap
    logic [IDX_W-1:0] nxt_in, nxt_out;
    logic             scan_init;
    pss_pkg::func_t   init_func;
    logic             is_sched, hit;
    logic [CNT_W-1:0] limit;

    assign nxt_in  = (state_reg == S_SCAN) ? addr_reg : cur_reg;
    assign nxt_out = (nxt_in >= LAST_IDX) ? ONE_IDX : nxt_in + ONE_IDX;

    pss_table #(
        .DEPTH(SLOTS), .WIDTH(2), .AW(IDX_W), .RST_VAL(pss_pkg::ST_EXIT)
    ) u_status (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
        .rd_addr(addr_reg), .rd_data(st_rd)
    );

    pss_table #(
        .DEPTH(SLOTS), .WIDTH(IDX_W), .AW(IDX_W), .RST_VAL('0)
    ) u_parent (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(par_we), .wr_addr(par_wa), .wr_data(par_wd),
        .rd_addr(cur_reg), .rd_data(par_rd)
    );

    pss_table #(
        .DEPTH(SLOTS), .WIDTH(8), .AW(IDX_W), .RST_VAL(8'h00)
    ) u_mailbox (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(mb_we), .wr_addr(mb_wa), .wr_data(mb_wd),
        .rd_addr(cur_reg), .rd_data(mb_rd)
    );

    assign is_sched = (func_reg != pss_pkg::FN_FORK);
    assign limit    = is_sched ? CNT_W'(SLOTS) : CNT_W'(SLOTS - 1);
    // schedule stops at the first running slot, fork at the first slot not running
    assign hit = chk_vld_reg &&
                 (is_sched ? (st_rd == pss_pkg::ST_RUN) : (st_rd != pss_pkg::ST_RUN));

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        slot_next     = slot_reg;
        value_next    = value_reg;
        cur_next      = cur_reg;
        addr_next     = addr_reg;
        iss_next      = iss_reg;
        chk_vld_next  = chk_vld_reg;
        chk_idx_next  = chk_idx_reg;
        have_rdy_next = have_rdy_reg;
        rdy_idx_next  = rdy_idx_reg;
        hit_idx_next  = hit_idx_reg;
        res_next      = res_reg;
        fail_next     = fail_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        scan_init     = 1'b0;
        init_func     = func_reg;
        st_we  = 1'b0; st_wa  = cur_reg; st_wd  = pss_pkg::ST_EXIT;
        par_we = 1'b0; par_wa = cur_reg; par_wd = '0;
        mb_we  = 1'b0; mb_wa  = cur_reg; mb_wd  = 8'h00;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next  = s_data.func;
                    slot_next  = s_data.slot;
                    value_next = s_data.value;
                    res_next   = 8'h00;
                    fail_next  = 1'b0;
                    init_func  = s_data.func;
                    case (s_data.func)
                        pss_pkg::FN_SCHEDULE,
                        pss_pkg::FN_FORK: begin
                            state_next = S_SCAN;
                            scan_init  = 1'b1;
                        end
                        pss_pkg::FN_START: state_next = S_START;
                        default:           state_next = S_UPD;
                    endcase
                end
            end
            S_UPD: begin
                // set the current slot's status
                st_we = 1'b1;
                case (func_reg)
                    pss_pkg::FN_RUN: begin
                        st_wd      = pss_pkg::ST_RUN;
                        state_next = S_FINISH;
                    end
                    pss_pkg::FN_BLOCK: begin
                        st_wd      = pss_pkg::ST_BLOCKED;
                        state_next = S_FINISH;
                    end
                    pss_pkg::FN_WAIT: begin
                        st_wd      = pss_pkg::ST_BLOCKED;
                        state_next = S_SCAN;
                        scan_init  = 1'b1;
                    end
                    pss_pkg::FN_EXIT_TO_PARENT: begin
                        st_wd      = pss_pkg::ST_EXIT;
                        state_next = S_PAR_WR;
                    end
                    default: begin
                        st_wd      = pss_pkg::ST_EXIT;
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_PAR_WR: begin
                // wake the parent and drop the value in its mailbox
                st_we = 1'b1; st_wa = par_rd; st_wd = pss_pkg::ST_READY;
                mb_we = 1'b1; mb_wa = par_rd; mb_wd = value_reg;
                state_next = S_SCAN;
                scan_init  = 1'b1;
            end
            S_START: begin
                if (32'(slot_reg) < SLOTS) begin
                    st_we  = 1'b1; st_wa  = IDX_W'(slot_reg); st_wd = pss_pkg::ST_RUN;
                    par_we = 1'b1; par_wa = IDX_W'(slot_reg); par_wd = '0;
                end
                state_next = S_FINISH;
            end
            S_SCAN: begin
                if (hit) begin
                    chk_vld_next = 1'b0;
                    if (is_sched) begin
                        cur_next   = chk_idx_reg;
                        state_next = (func_reg == pss_pkg::FN_WAIT) ? S_MB_RD : S_FINISH;
                    end else begin
                        hit_idx_next = chk_idx_reg;
                        state_next   = S_FORK_WR;
                    end
                end else begin
                    if (chk_vld_reg && is_sched && !have_rdy_reg &&
                        st_rd == pss_pkg::ST_READY) begin
                        have_rdy_next = 1'b1;
                        rdy_idx_next  = chk_idx_reg;
                    end
                    if (iss_reg != limit) begin
                        chk_vld_next = 1'b1;
                        chk_idx_next = addr_reg;
                        addr_next    = nxt_out;
                        iss_next     = iss_reg + CNT_W'(1);
                    end else begin
                        chk_vld_next = 1'b0;
                        if (!chk_vld_reg) begin
                            if (is_sched) begin
                                cur_next   = have_rdy_reg ? rdy_idx_reg : '0;
                                state_next = (func_reg == pss_pkg::FN_WAIT) ?
                                             S_MB_RD : S_FINISH;
                            end else begin
                                state_next = S_FORK_FAIL;
                            end
                        end
                    end
                end
            end
            S_MB_RD: state_next = S_MB_DATA;
            S_MB_DATA: begin
                res_next   = mb_rd;
                state_next = S_FINISH;
            end
            S_FORK_WR: begin
                st_we  = 1'b1; st_wa  = hit_idx_reg; st_wd  = pss_pkg::ST_READY;
                par_we = 1'b1; par_wa = hit_idx_reg; par_wd = cur_reg;
                mb_we  = 1'b1; mb_wa  = hit_idx_reg; mb_wd  = 8'h00;
                if (hit_idx_reg != cur_reg) begin
                    res_next   = 8'(hit_idx_reg);
                    state_next = S_FORK_MB;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FORK_MB: begin
                mb_we = 1'b1; mb_wa = cur_reg; mb_wd = 8'(hit_idx_reg);
                state_next = S_FINISH;
            end
            S_FORK_FAIL: begin
                mb_we = 1'b1; mb_wa = cur_reg; mb_wd = pss_pkg::FORK_FAIL_CODE;
                res_next   = pss_pkg::FORK_FAIL_CODE;
                fail_next  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.current_slot = 3'(cur_reg);
                    m_data_next.result_value = res_reg;
                    m_data_next.fork_failed  = fail_reg;
                    state_next               = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // start a scan: schedule begins after current, fork at slot 1
        if (scan_init) begin
            addr_next     = (init_func == pss_pkg::FN_FORK) ? ONE_IDX : nxt_out;
            iss_next      = '0;
            chk_vld_next  = 1'b0;
            have_rdy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
            chk_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
            chk_vld_reg <= chk_vld_next;
        end
        func_reg     <= func_next;
        slot_reg     <= slot_next;
        value_reg    <= value_next;
        addr_reg     <= addr_next;
        iss_reg      <= iss_next;
        chk_idx_reg  <= chk_idx_next;
        have_rdy_reg <= have_rdy_next;
        rdy_idx_reg  <= rdy_idx_next;
        hit_idx_reg  <= hit_idx_next;
        res_reg      <= res_next;
        fail_reg     <= fail_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[rtl/pss_checker.sv]
// ----------------------------------------------------------------------------
// pss_checker: port-level checks of the process slot scheduler
// Watches both channels and flags result and handshake slips.
// ----------------------------------------------------------------------------
module pss_checker #(
    parameter int unsigned SLOTS = 8
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input pss_pkg::out_t m_data
);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // one command at a time: ready drops after each accepted beat
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second command taken while busy");

    // a failed fork always reports the failure code
    a_fork_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.fork_failed |-> m_data.result_value == pss_pkg::FORK_FAIL_CODE)
        else $error("fork failure without failure code");

    // current slot stays inside the table
    a_cur_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (SLOTS >= 8) || (32'(m_data.current_slot) < SLOTS))
        else $error("current slot out of range");

endmodule

bind process_slot_scheduler pss_checker #(.SLOTS(SLOTS)) u_pss_checker (.*);
